### hdl/srcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srcs_pkg
// Shared constants and the pipeline stage record of the stick curve shaper.
// ----------------------------------------------------------------------------
package srcs_pkg;

  localparam int FracBits = 14;
  localparam logic [15:0] One = 16'd16384;

  // Configuration register indexes.
  localparam logic [2:0] REG_CURVE_MODE     = 3'd0;
  localparam logic [2:0] REG_OUTPUT_SCALE   = 3'd1;
  localparam logic [2:0] REG_EXPO_COEFF     = 3'd2;
  localparam logic [2:0] REG_EXPO_RATE      = 3'd3;
  localparam logic [2:0] REG_DEADZONE_WIDTH = 3'd4;
  localparam logic [2:0] REG_DEADZONE_FIRST = 3'd5;

  // Curve codes.
  localparam logic [3:0] MODE_LINEAR  = 4'd0;
  localparam logic [3:0] MODE_SQUARE  = 4'd1;
  localparam logic [3:0] MODE_CUBE    = 4'd2;
  localparam logic [3:0] MODE_ROOT    = 4'd3;
  localparam logic [3:0] MODE_SCURVE  = 4'd5;
  localparam logic [3:0] MODE_DZ_LIN  = 4'd6;
  localparam logic [3:0] MODE_EXPO    = 4'd7;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [16:0] c;
    logic               neg;
    logic        [14:0] q;
    logic signed [15:0] k;
    logic        [15:0] eq;
    logic signed [17:0] t;
    logic signed [18:0] u;
    logic               dz_zero;
    logic               dz_ovf;
    logic        [14:0] drem;
    logic        [15:0] dnum;
    logic        [15:0] dquo;
    logic        [29:0] sv;
    logic        [17:0] srem;
    logic        [14:0] sroot;
    logic signed [18:0] y;
    logic signed [20:0] ys;
    logic signed [15:0] res;
    logic               sat;
  } stage_t;

endpackage

### hdl/srcs_iter_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srcs_iter_stage
// One step of the restoring divider and of the digit-by-digit square root.
// ----------------------------------------------------------------------------
module srcs_iter_stage
  import srcs_pkg::*;
#(
  parameter int DIV_BIT   = 15,
  parameter int ROOT_PAIR = 14
) (
  input  stage_t      st_i,
  input  logic [14:0] divisor_i,
  output stage_t      st_o
);

  // The last divider step has no root pair left; keep the select in range.
  localparam int RootSel = (ROOT_PAIR >= 0) ? ROOT_PAIR : 0;

  logic [15:0] rem2;
  logic [19:0] rem4;
  logic [19:0] trial;

  always_comb begin
    st_o = st_i;
    // Division: shift in one numerator bit, subtract when it fits.
    rem2 = {st_i.drem, st_i.dnum[DIV_BIT]};
    if (rem2 >= {1'b0, divisor_i}) begin
      st_o.drem = 15'(rem2 - {1'b0, divisor_i});
      st_o.dquo = {st_i.dquo[14:0], 1'b1};
    end else begin
      st_o.drem = rem2[14:0];
      st_o.dquo = {st_i.dquo[14:0], 1'b0};
    end
    rem4  = '0;
    trial = '0;
    if (ROOT_PAIR >= 0) begin
      rem4  = {st_i.srem, st_i.sv[2*RootSel+1 -: 2]};
      trial = {3'b000, st_i.sroot, 2'b01};
      if (rem4 >= trial) begin
        st_o.srem  = 18'(rem4 - trial);
        st_o.sroot = {st_i.sroot[13:0], 1'b1};
      end else begin
        st_o.srem  = rem4[17:0];
        st_o.sroot = {st_i.sroot[13:0], 1'b0};
      end
    end
  end

endmodule

### hdl/stick_response_curve_shaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick_response_curve_shaper
// Deadzone, selectable response curve, output gain and 16-bit saturation.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while the output is not stalled; each of the 20
// stages holds its own request, so a stalled output only blocks once the pipeline has filled.
// The 16 divider steps set the depth, one bit per stage; all but the last also take a square-root step.
// Reset clears all valid bits and loads the register defaults.
module stick_response_curve_shaper
  import srcs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] stick_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] mapped_value_o,
  output logic               saturated_o
);

  localparam int NStages = 20;
  localparam int NIter   = 16;

  logic [3:0]  mode_q;
  logic [14:0] scale_q;
  logic [14:0] ecoef_q;
  logic [14:0] erate_q;
  logic [13:0] dzw_q;
  logic        dzf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LINEAR;
      scale_q <= 15'd16384;
      ecoef_q <= '0;
      erate_q <= 15'd16384;
      dzw_q   <= '0;
      dzf_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CURVE_MODE:     mode_q  <= cfg_data_i[3:0];
        REG_OUTPUT_SCALE:   scale_q <= cfg_data_i;
        REG_EXPO_COEFF:     ecoef_q <= cfg_data_i;
        REG_EXPO_RATE:      erate_q <= cfg_data_i;
        REG_DEADZONE_WIDTH: dzw_q   <= cfg_data_i[13:0];
        REG_DEADZONE_FIRST: dzf_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [14:0] divisor;
  assign divisor = 15'(One - {2'b00, dzw_q});

  stage_t             pipe_q [NStages];
  stage_t             pipe_d [NStages];
  logic [NStages-1:0] vld_q;
  logic [NStages-1:0] en;

  // Each stage advances when it is empty or its successor advances.
  always_comb begin
    en[NStages-1] = !vld_q[NStages-1] || out_ready_i;
    for (int i = NStages - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NStages; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NStages; i++) begin
      if (en[i]) begin
        pipe_q[i] <= pipe_d[i];
      end
    end
  end

  // Stage 0: pre-deadzone, clamp and operand setup for the iterative units.
  logic signed [16:0] xe;
  logic        [16:0] ax;
  logic               dz_hit;
  logic        [16:0] axd;
  logic        [16:0] adiff;
  logic        [14:0] cabs;

  always_comb begin
    pipe_d[0] = '0;
    xe     = {stick_value_i[15], stick_value_i};
    ax     = xe[16] ? 17'(-xe) : 17'(xe);
    dz_hit = dzf_q && (dzw_q != '0) && (ax < {3'b000, dzw_q});
    axd    = dz_hit ? '0 : ax;
    pipe_d[0].x   = dz_hit ? '0 : stick_value_i;
    pipe_d[0].neg = !dz_hit && stick_value_i[15];
    if (axd > 17'd16384) begin
      cabs = 15'd16384;
    end else begin
      cabs = axd[14:0];
    end
    pipe_d[0].c  = pipe_d[0].neg ? -$signed({2'b00, cabs}) : $signed({2'b00, cabs});
    pipe_d[0].sv = {1'b0, cabs, 14'b0};
    pipe_d[0].dz_zero = axd < {3'b000, dzw_q};
    adiff = 17'(axd - {3'b000, dzw_q});
    pipe_d[0].dz_ovf = adiff >= {divisor, 2'b00};
    pipe_d[0].drem   = adiff[16:2];
    pipe_d[0].dnum   = {adiff[1:0], 14'b0};
  end

  // Stages 1 to 16: one divider bit each and one root bit in all but the last,
  // with the polynomial products riding along in the first few stages.
  for (genvar g = 1; g <= NIter; g++) begin : g_iter
    stage_t             it_out;
    logic signed [33:0] prod_a;
    logic signed [34:0] prod_b;
    logic signed [17:0] blend;

    srcs_iter_stage #(
      .DIV_BIT  (NIter - g),
      .ROOT_PAIR(NIter - 1 - g)
    ) u_step (
      .st_i     (pipe_q[g-1]),
      .divisor_i(divisor),
      .st_o     (it_out)
    );

    always_comb begin
      pipe_d[g] = it_out;
      prod_a = '0;
      prod_b = '0;
      blend  = '0;
      if (g == 1) begin
        prod_a      = pipe_q[g-1].c * pipe_q[g-1].c;
        pipe_d[g].q = prod_a[28:14];
      end else if (g == 2) begin
        prod_a       = 34'($signed({1'b0, pipe_q[g-1].q}) * pipe_q[g-1].c);
        pipe_d[g].k  = prod_a[29:14];
        prod_b       = 35'($signed({1'b0, ecoef_q}) * $signed({1'b0, pipe_q[g-1].q}));
        pipe_d[g].eq = 16'(prod_b[34:14]);
      end else if (g == 3) begin
        blend = $signed(18'd16384) - $signed({3'b000, ecoef_q})
              + $signed({2'b00, pipe_q[g-1].eq});
        prod_b      = 35'(pipe_q[g-1].c * blend);
        pipe_d[g].t = prod_b[31:14];
      end else if (g == 4) begin
        prod_b      = 35'(pipe_q[g-1].t * $signed({1'b0, erate_q}));
        pipe_d[g].u = prod_b[32:14];
      end
    end
  end

  // Stage 17: curve select.
  localparam int SSel = NIter + 1;
  logic signed [18:0] qs;
  logic signed [18:0] ks;
  logic signed [18:0] rs;
  logic signed [18:0] dmag;

  always_comb begin
    pipe_d[SSel] = pipe_q[SSel-1];
    qs = $signed({4'b0000, pipe_q[SSel-1].q});
    ks = 19'(pipe_q[SSel-1].k);
    rs = $signed({4'b0000, pipe_q[SSel-1].sroot});
    if (pipe_q[SSel-1].dz_ovf || pipe_q[SSel-1].dquo > One) begin
      dmag = 19'sd16384;
    end else begin
      dmag = $signed({3'b000, pipe_q[SSel-1].dquo});
    end
    unique case (mode_q)
      MODE_LINEAR: pipe_d[SSel].y = 19'(pipe_q[SSel-1].c);
      MODE_SQUARE: pipe_d[SSel].y = pipe_q[SSel-1].neg ? -qs : qs;
      MODE_CUBE:   pipe_d[SSel].y = ks;
      MODE_ROOT:   pipe_d[SSel].y = pipe_q[SSel-1].neg ? -rs : rs;
      MODE_SCURVE: begin
        pipe_d[SSel].y = pipe_q[SSel-1].neg ? (-(qs * 19'sd3) - (ks * 19'sd2))
                                            : ((qs * 19'sd3) - (ks * 19'sd2));
      end
      MODE_DZ_LIN: begin
        if (pipe_q[SSel-1].dz_zero) begin
          pipe_d[SSel].y = '0;
        end else begin
          pipe_d[SSel].y = pipe_q[SSel-1].neg ? -dmag : dmag;
        end
      end
      MODE_EXPO:   pipe_d[SSel].y = pipe_q[SSel-1].u;
      default:     pipe_d[SSel].y = 19'(pipe_q[SSel-1].x);
    endcase
  end

  // Stage 18: output gain, skipped for expo and the pass-through codes.
  localparam int SScl = SSel + 1;
  logic        scaled;
  logic signed [34:0] sprod;

  always_comb begin
    pipe_d[SScl] = pipe_q[SScl-1];
    scaled = (mode_q == MODE_LINEAR) || (mode_q == MODE_SQUARE) ||
             (mode_q == MODE_CUBE) || (mode_q == MODE_ROOT) ||
             (mode_q == MODE_SCURVE) || (mode_q == MODE_DZ_LIN);
    sprod = 35'(pipe_q[SScl-1].y * $signed({1'b0, scale_q}));
    pipe_d[SScl].ys = scaled ? sprod[34:14] : 21'(pipe_q[SScl-1].y);
  end

  // Stage 19: saturation into the output register.
  localparam int SSat = SScl + 1;

  always_comb begin
    pipe_d[SSat] = pipe_q[SSat-1];
    if (pipe_q[SSat-1].ys > 21'sd32767) begin
      pipe_d[SSat].res = 16'sh7fff;
      pipe_d[SSat].sat = 1'b1;
    end else if (pipe_q[SSat-1].ys < -21'sd32768) begin
      pipe_d[SSat].res = 16'sh8000;
      pipe_d[SSat].sat = 1'b1;
    end else begin
      pipe_d[SSat].res = pipe_q[SSat-1].ys[15:0];
      pipe_d[SSat].sat = 1'b0;
    end
  end

  assign out_valid_o    = vld_q[NStages-1];
  assign mapped_value_o = pipe_q[NStages-1].res;
  assign saturated_o    = pipe_q[NStages-1].sat;

endmodule
